// ----- design/traffic_crossing_controller_top_assert.svh -----
// Assertion macros for the traffic crossing controller top level.
// Included by traffic_crossing_controller_top.sv; depends on nothing else.
`ifndef TRAFFIC_CROSSING_CONTROLLER_TOP_ASSERT_SVH
`define TRAFFIC_CROSSING_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcc_pkg.sv -----
// Shared types, codes and constants of the traffic crossing controller.
// Used by tcc_step_logic and traffic_crossing_controller_top; no dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

    // Default width of the stored expiry time.
    localparam int TCC_TIME_BITS = 32;

    // Expiry value after reset and after every phase advance.
    localparam logic [15:0] EXPIRE_RESET = 16'hFFFF;

    // Lamp bit positions.
    localparam int LMP_Y_T = 0;
    localparam int LMP_Y_B = 1;
    localparam int LMP_Y_L = 2;
    localparam int LMP_Y_R = 3;
    localparam int LMP_G_T = 4;
    localparam int LMP_G_B = 5;
    localparam int LMP_G_L = 6;
    localparam int LMP_G_R = 7;
    localparam int LMP_R_T = 8;
    localparam int LMP_R_B = 9;
    localparam int LMP_R_L = 10;
    localparam int LMP_R_R = 11;
    localparam int LMP_W_T = 12;
    localparam int LMP_W_L = 13;
    localparam int LMP_S_T = 14;
    localparam int LMP_S_L = 15;

    // Operation of an input item.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MODE      = 3'd0,
        CFG_PED_WAIT  = 3'd1,
        CFG_WALKING   = 3'd2,
        CFG_YELLOW    = 3'd3,
        CFG_GREEN     = 3'd4,
        CFG_RED_MAX   = 3'd5
    } t_cfg_idx;

    // Crossing modes; the fourth code selects no mode.
    typedef enum logic [1:0] {
        MODE_ONE_LANE_PED = 2'd0,
        MODE_TWO_LANE     = 2'd1,
        MODE_TWO_LANE_PED = 2'd2
    } t_mode;

    // Light phases, one-hot.
    typedef enum logic [5:0] {
        PH_H   = 6'b000001,
        PH_V   = 6'b000010,
        PH_VW  = 6'b000100,
        PH_HW  = 6'b001000,
        PH_TOH = 6'b010000,
        PH_TOV = 6'b100000
    } t_phase;

    // Phase codes as seen on the result.
    localparam logic [2:0] PHC_H   = 3'd0;
    localparam logic [2:0] PHC_V   = 3'd1;
    localparam logic [2:0] PHC_VW  = 3'd2;
    localparam logic [2:0] PHC_HW  = 3'd3;
    localparam logic [2:0] PHC_TOH = 3'd4;
    localparam logic [2:0] PHC_TOV = 3'd5;

    typedef struct packed {
        logic        op;
        logic        top_ped;
        logic        left_ped;
        logic        top_car;
        logic        bottom_car;
        logic        left_car;
        logic        right_car;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [15:0] lamps;
        logic        timer_request;
        logic [15:0] hold_ms;
        logic        top_waiting;
        logic        left_waiting;
        logic [2:0]  phase;
    } t_out_item;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] ped_wait_ms;
        logic [15:0] walking_ms;
        logic [15:0] yellow_ms;
        logic [15:0] green_ms;
        logic [15:0] red_max_ms;
    } t_cfg;

    // Controller state apart from the expiry time.
    typedef struct packed {
        t_phase      cur_phase;
        t_phase      chosen_phase;
        logic        lamps_set;
        logic        hold_sent;
        logic [15:0] lamps;
        logic        req_flag;
        logic [15:0] hold_ms;
        logic        top_wait;
        logic        left_wait;
    } t_state;

    // Encode a one-hot phase into its result code.
    function automatic logic [2:0] tcc_phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_H:    code = PHC_H;
            PH_V:    code = PHC_V;
            PH_VW:   code = PHC_VW;
            PH_HW:   code = PHC_HW;
            PH_TOH:  code = PHC_TOH;
            PH_TOV:  code = PHC_TOV;
            default: code = PHC_H;
        endcase
        return code;
    endfunction

endpackage

// ----- design/tcc_step_logic.sv -----
// Next-state logic of the crossing controller for one input item.
// Purely combinational; depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_step_logic
    import tcc_pkg::*;
#(
    parameter int TIME_BITS = TCC_TIME_BITS
) (
    input  t_state               i_state,
    input  logic [TIME_BITS-1:0] i_expire,
    input  t_cfg                 i_cfg,
    input  t_in_item             i_item,
    output t_state               o_state,
    output logic [TIME_BITS-1:0] o_expire
);

    logic                 tp;
    logic                 lp;
    logic                 car_v;
    logic                 car_h;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] now_p1;
    logic [TIME_BITS-1:0] now_red;
    logic [TIME_BITS-1:0] now_green;
    logic [TIME_BITS-1:0] now_pw;

    // Sensor decode and the candidate expiry times, wrapped at TIME_BITS.
    assign tp        = i_item.top_ped;
    assign lp        = i_item.left_ped;
    assign car_v     = i_item.top_car | i_item.bottom_car;
    assign car_h     = i_item.left_car | i_item.right_car;
    assign now_t     = TIME_BITS'(i_item.now_ms);
    assign now_p1    = now_t + TIME_BITS'(1);
    assign now_red   = now_t + TIME_BITS'(i_cfg.red_max_ms);
    assign now_green = now_t + TIME_BITS'(i_cfg.green_ms);
    assign now_pw    = now_t + TIME_BITS'(i_cfg.ped_wait_ms);

    // Car lamps of a car phase with the walk and stop lamps, yellow off.
    function automatic logic [15:0] car_lamps(input logic [15:0] l_in, input logic v,
                                              input logic walk_t, input logic walk_l);
        logic [15:0] l;
        l = l_in;
        if (v) begin
            l[LMP_G_B] = 1'b1; l[LMP_G_T] = 1'b1; l[LMP_R_L] = 1'b1; l[LMP_R_R] = 1'b1;
        end else begin
            l[LMP_G_L] = 1'b1; l[LMP_G_R] = 1'b1; l[LMP_R_T] = 1'b1; l[LMP_R_B] = 1'b1;
        end
        l[LMP_W_T] = walk_t;
        l[LMP_W_L] = walk_l;
        l[LMP_S_T] = ~walk_t;
        l[LMP_S_L] = ~walk_l;
        l[LMP_Y_T] = 1'b0; l[LMP_Y_B] = 1'b0; l[LMP_Y_L] = 1'b0; l[LMP_Y_R] = 1'b0;
        return l;
    endfunction

    // Evaluate one sample or advance against the current state.
    always_comb begin
        t_state               s;
        logic [TIME_BITS-1:0] ex;
        logic                 v;
        logic                 mark;
        logic                 own_ped;
        logic                 other_ped;
        logic                 other_wait;
        logic                 stay;

        s          = i_state;
        ex         = i_expire;
        v          = 1'b0;
        mark       = 1'b0;
        own_ped    = 1'b0;
        other_ped  = 1'b0;
        other_wait = 1'b0;
        stay       = 1'b0;

        if (i_item.op == OP_ADVANCE) begin
            s.cur_phase = i_state.chosen_phase;
            s.hold_sent = 1'b0;
            s.lamps_set = 1'b0;
            ex          = TIME_BITS'(EXPIRE_RESET);
        end else begin
            case (i_cfg.mode)
                // One lane with the top pedestrian crossing.
                MODE_ONE_LANE_PED: begin
                    case (i_state.cur_phase)
                        PH_H: begin
                            s.chosen_phase = PH_TOV;
                            if (!s.lamps_set) begin
                                s.lamps[LMP_Y_T] = 1'b0; s.lamps[LMP_Y_B] = 1'b0;
                                s.lamps[LMP_G_B] = 1'b1; s.lamps[LMP_G_T] = 1'b1;
                                s.lamps[LMP_R_T] = 1'b0; s.lamps[LMP_R_B] = 1'b0;
                                s.lamps[LMP_S_T] = 1'b1;
                                s.lamps_set = 1'b1;
                            end
                            if (tp && !s.hold_sent) begin
                                s.hold_ms   = i_cfg.ped_wait_ms;
                                s.req_flag  = 1'b1;
                                s.top_wait  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        PH_VW: begin
                            s.chosen_phase = PH_TOH;
                            if (!s.lamps_set) begin
                                s.lamps[LMP_Y_T] = 1'b0; s.lamps[LMP_Y_B] = 1'b0;
                                s.lamps[LMP_W_T] = 1'b1; s.lamps[LMP_S_T] = 1'b0;
                                s.lamps[LMP_R_T] = 1'b1; s.lamps[LMP_R_B] = 1'b1;
                                s.lamps_set = 1'b1;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.walking_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        PH_TOH: begin
                            s.chosen_phase = PH_H;
                            if (!s.lamps_set) begin
                                s.lamps[LMP_W_T] = 1'b0; s.lamps[LMP_S_T] = 1'b1;
                                s.lamps[LMP_R_T] = 1'b0; s.lamps[LMP_R_B] = 1'b0;
                                s.lamps[LMP_Y_T] = 1'b1; s.lamps[LMP_Y_B] = 1'b1;
                                s.lamps_set = 1'b1;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.yellow_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        PH_TOV: begin
                            s.chosen_phase = PH_VW;
                            if (!s.lamps_set) begin
                                s.lamps[LMP_Y_T] = 1'b1; s.lamps[LMP_Y_B] = 1'b1;
                                s.lamps[LMP_G_B] = 1'b0; s.lamps[LMP_G_T] = 1'b0;
                                s.lamps_set = 1'b1;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.yellow_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Two lanes, no pedestrians.
                MODE_TWO_LANE: begin
                    case (i_state.cur_phase) inside
                        PH_V, PH_H: begin
                            v = (i_state.cur_phase == PH_V);
                            s.chosen_phase = v ? PH_TOH : PH_TOV;
                            if (!s.lamps_set) begin
                                if (v) begin
                                    s.lamps[LMP_G_B] = 1'b1; s.lamps[LMP_G_T] = 1'b1;
                                end else begin
                                    s.lamps[LMP_G_R] = 1'b1; s.lamps[LMP_G_L] = 1'b1;
                                end
                                s.lamps[LMP_Y_T] = 1'b0; s.lamps[LMP_Y_B] = 1'b0;
                                s.lamps[LMP_Y_L] = 1'b0; s.lamps[LMP_Y_R] = 1'b0;
                                if (v) begin
                                    s.lamps[LMP_R_L] = 1'b1; s.lamps[LMP_R_R] = 1'b1;
                                end else begin
                                    s.lamps[LMP_R_T] = 1'b1; s.lamps[LMP_R_B] = 1'b1;
                                end
                                s.lamps_set = 1'b1;
                            end
                            // Cars wait only on the red road: switch soon.
                            if (v ? (car_h && !car_v) : (!car_h && car_v)) begin
                                s.hold_ms   = 16'd1;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end else if (car_h && car_v && !s.hold_sent) begin
                                s.hold_ms   = i_cfg.red_max_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end else if (!car_h && !car_v && !s.hold_sent) begin
                                s.hold_ms   = i_cfg.green_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        PH_TOH, PH_TOV: begin
                            v = (i_state.cur_phase == PH_TOH);
                            s.chosen_phase = v ? PH_H : PH_V;
                            if (!s.lamps_set) begin
                                s.lamps[LMP_Y_T] = 1'b1; s.lamps[LMP_Y_B] = 1'b1;
                                s.lamps[LMP_Y_L] = 1'b1; s.lamps[LMP_Y_R] = 1'b1;
                                if (v) begin
                                    s.lamps[LMP_G_T] = 1'b0; s.lamps[LMP_G_B] = 1'b0;
                                    s.lamps[LMP_R_R] = 1'b0; s.lamps[LMP_R_L] = 1'b0;
                                end else begin
                                    s.lamps[LMP_G_R] = 1'b0; s.lamps[LMP_G_L] = 1'b0;
                                    s.lamps[LMP_R_T] = 1'b0; s.lamps[LMP_R_B] = 1'b0;
                                end
                                s.lamps_set = 1'b1;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.yellow_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Two lanes with top and left pedestrian crossings.
                MODE_TWO_LANE_PED: begin
                    case (i_state.cur_phase) inside
                        PH_V, PH_H: begin
                            v         = (i_state.cur_phase == PH_V);
                            mark      = ~v;
                            own_ped   = v ? lp : tp;
                            other_ped = v ? tp : lp;
                            s.chosen_phase = v ? PH_TOH : PH_TOV;
                            if (!s.lamps_set) begin
                                s.lamps     = car_lamps(s.lamps, v, 1'b0, 1'b0);
                                s.lamps_set = 1'b1;
                            end
                            if (own_ped) begin
                                s.chosen_phase = v ? PH_VW : PH_HW;
                            end
                            if (own_ped || (v ? (car_h && !car_v) : (!car_h && car_v))) begin
                                s.hold_ms  = 16'd1;
                                s.req_flag = 1'b1;
                                ex         = now_p1;
                                if (mark) s.hold_sent = 1'b1;
                            end
                            // Shorten the pending hold only if it ends later.
                            if (car_h && car_v && (ex > now_red)) begin
                                s.hold_ms  = i_cfg.red_max_ms;
                                s.req_flag = 1'b1;
                                ex         = now_red;
                                if (mark) s.hold_sent = 1'b1;
                            end else if (!car_h && !car_v && (ex > now_green)) begin
                                s.hold_ms  = i_cfg.green_ms;
                                s.req_flag = 1'b1;
                                ex         = now_green;
                                if (mark) s.hold_sent = 1'b1;
                            end
                            if (other_ped) begin
                                if (v) s.top_wait = 1'b1;
                                else   s.left_wait = 1'b1;
                                s.hold_ms  = i_cfg.ped_wait_ms;
                                s.req_flag = 1'b1;
                                ex         = now_pw;
                                if (mark) s.hold_sent = 1'b1;
                            end
                        end
                        PH_VW, PH_HW: begin
                            v          = (i_state.cur_phase == PH_VW);
                            other_wait = v ? i_state.top_wait : i_state.left_wait;
                            stay       = v ? (car_v && !car_h) : (car_h && !car_v);
                            if (other_wait)  s.chosen_phase = v ? PH_TOH : PH_TOV;
                            else if (stay)   s.chosen_phase = v ? PH_V : PH_H;
                            else             s.chosen_phase = v ? PH_TOH : PH_TOV;
                            if (!s.lamps_set) begin
                                s.lamps = car_lamps(s.lamps, v, ~v, v);
                                if (v) s.left_wait = 1'b0;
                                else   s.top_wait = 1'b0;
                                s.lamps_set = 1'b1;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.walking_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                            if (v ? tp : lp) begin
                                if (v) s.top_wait = 1'b1;
                                else   s.left_wait = 1'b1;
                            end
                        end
                        PH_TOH, PH_TOV: begin
                            if (!s.lamps_set) begin
                                s.lamps[LMP_G_L] = 1'b0; s.lamps[LMP_G_R] = 1'b0;
                                s.lamps[LMP_G_T] = 1'b0; s.lamps[LMP_G_B] = 1'b0;
                                s.lamps[LMP_R_T] = 1'b0; s.lamps[LMP_R_B] = 1'b0;
                                s.lamps[LMP_R_L] = 1'b0; s.lamps[LMP_R_R] = 1'b0;
                                s.lamps[LMP_W_T] = 1'b0; s.lamps[LMP_W_L] = 1'b0;
                                s.lamps[LMP_S_T] = 1'b1; s.lamps[LMP_S_L] = 1'b1;
                                s.lamps[LMP_Y_T] = 1'b1; s.lamps[LMP_Y_B] = 1'b1;
                                s.lamps[LMP_Y_L] = 1'b1; s.lamps[LMP_Y_R] = 1'b1;
                                s.lamps_set = 1'b1;
                            end
                            if (tp) s.top_wait = 1'b1;
                            if (lp) s.left_wait = 1'b1;
                            if (i_state.cur_phase == PH_TOH) begin
                                s.chosen_phase = s.top_wait ? PH_HW : PH_H;
                            end else begin
                                s.chosen_phase = s.left_wait ? PH_VW : PH_V;
                            end
                            if (!s.hold_sent) begin
                                s.hold_ms   = i_cfg.yellow_ms;
                                s.req_flag  = 1'b1;
                                s.hold_sent = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // The unused mode code leaves everything as it is.
                default: begin
                end
            endcase
        end

        o_state  = s;
        o_expire = ex;
    end

endmodule

// ----- design/traffic_crossing_controller_top.sv -----
// Traffic crossing controller: input register, state, result register.
// Depends on tcc_pkg, tcc_step_logic and traffic_crossing_controller_top_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries sensor samples
//   and advance events. Result channel (o_out_valid / i_out_ready / o_out_data)
//   returns one result per item: lamps, timer request, hold time, pedestrian
//   waiting flags and the current phase, all as they stand after that item.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   is always ready; write it only while the block is idle.
// Timing:
//   An item transfer lands in the input register; it is evaluated there and
//   loads the result register once that register is empty or being read, and
//   o_out_valid rises when the result register is loaded. One item per cycle is
//   sustained while results are taken, set by the combinational state update
//   between the input and result registers.
// Reset (synchronous, active low): phase H, no lamps lit, no request, flags
//   clear, expiry time 65535, registers 0, both pipeline stages empty.
// Stall: while the result is not taken, the item in the input register waits
//   and o_in_ready drops once both stages are full; nothing is lost.
`timescale 1ns / 1ps

module traffic_crossing_controller_top
    import tcc_pkg::*;
#(
    parameter int TIME_BITS = TCC_TIME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg                 r_cfg;
    t_state               r_state;
    t_state               n_state;
    logic [TIME_BITS-1:0] r_expire;
    logic [TIME_BITS-1:0] n_expire;
    logic                 r_in_valid;
    t_in_item             r_in_item;
    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 proc;

    // The input register item is evaluated when the result register can take it.
    assign proc        = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready  = ~r_in_valid | proc;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:     r_cfg.mode        <= t_mode'(i_cfg_data[1:0]);
                CFG_PED_WAIT: r_cfg.ped_wait_ms <= i_cfg_data;
                CFG_WALKING:  r_cfg.walking_ms  <= i_cfg_data;
                CFG_YELLOW:   r_cfg.yellow_ms   <= i_cfg_data;
                CFG_GREEN:    r_cfg.green_ms    <= i_cfg_data;
                CFG_RED_MAX:  r_cfg.red_max_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Decision logic for the item in the input register.
    tcc_step_logic #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_state  (r_state),
        .i_expire (r_expire),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_expire (n_expire)
    );

    // Controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_phase    <= PH_H;
            r_state.chosen_phase <= PH_H;
            r_state.lamps_set    <= 1'b0;
            r_state.hold_sent    <= 1'b0;
            r_state.lamps        <= '0;
            r_state.req_flag     <= 1'b0;
            r_state.hold_ms      <= '0;
            r_state.top_wait     <= 1'b0;
            r_state.left_wait    <= 1'b0;
            r_expire             <= TIME_BITS'(EXPIRE_RESET);
        end else if (proc) begin
            r_state  <= n_state;
            r_expire <= n_expire;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_item.lamps         <= n_state.lamps;
            r_out_item.timer_request <= n_state.req_flag;
            r_out_item.hold_ms       <= n_state.hold_ms;
            r_out_item.top_waiting   <= n_state.top_wait;
            r_out_item.left_waiting  <= n_state.left_wait;
            r_out_item.phase         <= tcc_phase_code(n_state.cur_phase);
        end
    end

    // Checks on the pipeline and on the latched request.
    `include "traffic_crossing_controller_top_assert.svh"

    `TCC_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !o_in_ready,
        r_in_valid && r_out_valid && !i_out_ready, "input stalled with a free stage")
    `TCC_ASSERT_NXT(a_request_sticks, i_clk, i_rst_n, r_state.req_flag,
        r_state.req_flag, "timer request dropped after being raised")
    `TCC_ASSERT_NXT(a_advance_clears, i_clk, i_rst_n,
        proc && (r_in_item.op == OP_ADVANCE),
        !r_state.lamps_set && !r_state.hold_sent && r_out_valid,
        "advance did not restart the phase")

endmodule

// ----- tb/sv/tb_traffic_crossing_controller_top.sv -----
// Self-checking testbench for the traffic crossing controller top level.
// Depends on tcc_pkg and traffic_crossing_controller_top; it drives random traffic
// and compares every result against a cycle-free behavioral predictor.
`timescale 1ns / 1ps

module tb_traffic_crossing_controller_top;
    import tcc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEMS_PER_RUN = 40;
    localparam int RANDOM_RUNS = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    traffic_crossing_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration registers.
    logic [1:0]  cfg_mode = '0;
    logic [15:0] cfg_ped_wait = '0;
    logic [15:0] cfg_walking = '0;
    logic [15:0] cfg_yellow = '0;
    logic [15:0] cfg_green = '0;
    logic [15:0] cfg_red_max = '0;

    // Predictor copy of the controller state, at its reset values.
    logic [2:0]  ph_now = PHC_H;
    logic [2:0]  ph_next = PHC_H;
    bit          lamps_done = 1'b0;
    bit          hold_done = 1'b0;
    bit          req_on = 1'b0;
    bit          top_wait = 1'b0;
    bit          left_wait = 1'b0;
    logic [31:0] expiry = {16'd0, EXPIRE_RESET};
    logic [15:0] lamp_bits = '0;
    logic [15:0] hold_val = '0;

    t_in_item    sensor_q[$];
    t_out_item   lights_due_q[$];

    int          accepted_cnt = 0;
    int          issued_cnt = 0;
    int          result_cnt = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          in_gap_max = 18;
    int          out_gap_max = 18;
    logic [31:0] clock_ms = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Small helpers that mirror the lamp and hold-request bookkeeping.
    function automatic void set_lamp(int idx, bit on);
        lamp_bits[idx] = on;
    endfunction

    function automatic void set_yellow(bit on, bit both_roads);
        lamp_bits[LMP_Y_T] = on;
        lamp_bits[LMP_Y_B] = on;
        if (both_roads) begin
            lamp_bits[LMP_Y_L] = on;
            lamp_bits[LMP_Y_R] = on;
        end
    endfunction

    function automatic void put_request(logic [15:0] ms);
        hold_val = ms;
        req_on = 1'b1;
    endfunction

    function automatic void request_once(logic [15:0] ms);
        if (!hold_done) begin
            put_request(ms);
            hold_done = 1'b1;
        end
    endfunction

    // The stored expiry wraps at 32 bits, like the free-running time.
    function automatic void set_expiry(logic [31:0] now, logic [15:0] dly, bit mark);
        expiry = now + 32'(dly);
        if (mark) hold_done = 1'b1;
    endfunction

    function automatic void car_lamps(bit v, bit walk_t, bit walk_l);
        if (v) begin
            set_lamp(LMP_G_B, 1'b1); set_lamp(LMP_G_T, 1'b1);
            set_lamp(LMP_R_L, 1'b1); set_lamp(LMP_R_R, 1'b1);
        end else begin
            set_lamp(LMP_G_L, 1'b1); set_lamp(LMP_G_R, 1'b1);
            set_lamp(LMP_R_T, 1'b1); set_lamp(LMP_R_B, 1'b1);
        end
        set_lamp(LMP_W_T, walk_t);
        set_lamp(LMP_W_L, walk_l);
        set_lamp(LMP_S_T, !walk_t);
        set_lamp(LMP_S_L, !walk_l);
        set_yellow(1'b0, 1'b1);
    endfunction

    // Applies one accepted item to the predicted state and returns the lights it leaves.
    function automatic t_out_item crossing_outcome(t_in_item it);
        t_out_item   res;
        bit          tp, lp, car_v, car_h, v, mark, own_ped, other_ped, other_wait, stay;
        logic [31:0] red_lim, green_lim;
        tp = it.top_ped;
        lp = it.left_ped;
        car_v = it.top_car | it.bottom_car;
        car_h = it.left_car | it.right_car;
        red_lim = it.now_ms + 32'(cfg_red_max);
        green_lim = it.now_ms + 32'(cfg_green);
        if (it.op == OP_ADVANCE) begin
            ph_now = ph_next;
            hold_done = 1'b0;
            lamps_done = 1'b0;
            expiry = {16'd0, EXPIRE_RESET};
        end else begin
            case (cfg_mode)
                // One lane, top pedestrian crossing.
                MODE_ONE_LANE_PED: begin
                    case (ph_now)
                        PHC_H: begin
                            ph_next = PHC_TOV;
                            if (!lamps_done) begin
                                set_yellow(1'b0, 1'b0);
                                set_lamp(LMP_G_B, 1'b1); set_lamp(LMP_G_T, 1'b1);
                                set_lamp(LMP_R_T, 1'b0); set_lamp(LMP_R_B, 1'b0);
                                set_lamp(LMP_S_T, 1'b1);
                                lamps_done = 1'b1;
                            end
                            if (tp && !hold_done) begin
                                put_request(cfg_ped_wait);
                                top_wait = 1'b1;
                                hold_done = 1'b1;
                            end
                        end
                        PHC_VW: begin
                            ph_next = PHC_TOH;
                            if (!lamps_done) begin
                                set_yellow(1'b0, 1'b0);
                                set_lamp(LMP_W_T, 1'b1); set_lamp(LMP_S_T, 1'b0);
                                set_lamp(LMP_R_T, 1'b1); set_lamp(LMP_R_B, 1'b1);
                                lamps_done = 1'b1;
                            end
                            request_once(cfg_walking);
                        end
                        PHC_TOH: begin
                            ph_next = PHC_H;
                            if (!lamps_done) begin
                                set_lamp(LMP_W_T, 1'b0); set_lamp(LMP_S_T, 1'b1);
                                set_lamp(LMP_R_T, 1'b0); set_lamp(LMP_R_B, 1'b0);
                                set_yellow(1'b1, 1'b0);
                                lamps_done = 1'b1;
                            end
                            request_once(cfg_yellow);
                        end
                        PHC_TOV: begin
                            ph_next = PHC_VW;
                            if (!lamps_done) begin
                                set_yellow(1'b1, 1'b0);
                                set_lamp(LMP_G_B, 1'b0); set_lamp(LMP_G_T, 1'b0);
                                lamps_done = 1'b1;
                            end
                            request_once(cfg_yellow);
                        end
                        default: ;
                    endcase
                end
                // Two lanes, no pedestrians.
                MODE_TWO_LANE: begin
                    case (ph_now)
                        PHC_V, PHC_H: begin
                            v = (ph_now == PHC_V);
                            ph_next = v ? PHC_TOH : PHC_TOV;
                            if (!lamps_done) begin
                                if (v) begin
                                    set_lamp(LMP_G_B, 1'b1); set_lamp(LMP_G_T, 1'b1);
                                end else begin
                                    set_lamp(LMP_G_R, 1'b1); set_lamp(LMP_G_L, 1'b1);
                                end
                                set_yellow(1'b0, 1'b1);
                                if (v) begin
                                    set_lamp(LMP_R_L, 1'b1); set_lamp(LMP_R_R, 1'b1);
                                end else begin
                                    set_lamp(LMP_R_T, 1'b1); set_lamp(LMP_R_B, 1'b1);
                                end
                                lamps_done = 1'b1;
                            end
                            // Cars waiting only on the red road get a quick switch.
                            if (v ? (car_h && !car_v) : (!car_h && car_v)) begin
                                put_request(16'd1);
                                hold_done = 1'b1;
                            end else if (car_h && car_v && !hold_done) begin
                                put_request(cfg_red_max);
                                hold_done = 1'b1;
                            end else if (!car_h && !car_v && !hold_done) begin
                                put_request(cfg_green);
                                hold_done = 1'b1;
                            end
                        end
                        PHC_TOH, PHC_TOV: begin
                            v = (ph_now == PHC_TOH);
                            ph_next = v ? PHC_H : PHC_V;
                            if (!lamps_done) begin
                                set_yellow(1'b1, 1'b1);
                                if (v) begin
                                    set_lamp(LMP_G_T, 1'b0); set_lamp(LMP_G_B, 1'b0);
                                    set_lamp(LMP_R_R, 1'b0); set_lamp(LMP_R_L, 1'b0);
                                end else begin
                                    set_lamp(LMP_G_R, 1'b0); set_lamp(LMP_G_L, 1'b0);
                                    set_lamp(LMP_R_T, 1'b0); set_lamp(LMP_R_B, 1'b0);
                                end
                                lamps_done = 1'b1;
                            end
                            request_once(cfg_yellow);
                        end
                        default: ;
                    endcase
                end
                // Two lanes with top and left pedestrian crossings.
                MODE_TWO_LANE_PED: begin
                    case (ph_now)
                        PHC_V, PHC_H: begin
                            v = (ph_now == PHC_V);
                            mark = !v;
                            own_ped = v ? lp : tp;
                            other_ped = v ? tp : lp;
                            ph_next = v ? PHC_TOH : PHC_TOV;
                            if (!lamps_done) begin
                                car_lamps(v, 1'b0, 1'b0);
                                lamps_done = 1'b1;
                            end
                            if (own_ped) begin
                                ph_next = v ? PHC_VW : PHC_HW;
                                put_request(16'd1);
                                set_expiry(it.now_ms, 16'd1, mark);
                            end else if (v ? (car_h && !car_v) : (!car_h && car_v)) begin
                                put_request(16'd1);
                                set_expiry(it.now_ms, 16'd1, mark);
                            end
                            if (car_h && car_v && expiry > red_lim) begin
                                put_request(cfg_red_max);
                                set_expiry(it.now_ms, cfg_red_max, mark);
                            end else if (!car_h && !car_v && expiry > green_lim) begin
                                put_request(cfg_green);
                                set_expiry(it.now_ms, cfg_green, mark);
                            end
                            if (other_ped) begin
                                if (v) top_wait = 1'b1;
                                else left_wait = 1'b1;
                                put_request(cfg_ped_wait);
                                set_expiry(it.now_ms, cfg_ped_wait, mark);
                            end
                        end
                        PHC_VW, PHC_HW: begin
                            v = (ph_now == PHC_VW);
                            other_wait = v ? top_wait : left_wait;
                            stay = v ? (car_v && !car_h) : (car_h && !car_v);
                            if (other_wait) ph_next = v ? PHC_TOH : PHC_TOV;
                            else if (stay) ph_next = v ? PHC_V : PHC_H;
                            else ph_next = v ? PHC_TOH : PHC_TOV;
                            if (!lamps_done) begin
                                car_lamps(v, !v, v);
                                if (v) left_wait = 1'b0;
                                else top_wait = 1'b0;
                                lamps_done = 1'b1;
                            end
                            request_once(cfg_walking);
                            if (v ? tp : lp) begin
                                if (v) top_wait = 1'b1;
                                else left_wait = 1'b1;
                            end
                        end
                        PHC_TOH, PHC_TOV: begin
                            if (!lamps_done) begin
                                set_lamp(LMP_G_L, 1'b0); set_lamp(LMP_G_R, 1'b0);
                                set_lamp(LMP_G_T, 1'b0); set_lamp(LMP_G_B, 1'b0);
                                set_lamp(LMP_R_T, 1'b0); set_lamp(LMP_R_B, 1'b0);
                                set_lamp(LMP_R_L, 1'b0); set_lamp(LMP_R_R, 1'b0);
                                set_lamp(LMP_W_T, 1'b0); set_lamp(LMP_W_L, 1'b0);
                                set_lamp(LMP_S_T, 1'b1); set_lamp(LMP_S_L, 1'b1);
                                set_yellow(1'b1, 1'b1);
                                lamps_done = 1'b1;
                            end
                            if (tp) top_wait = 1'b1;
                            if (lp) left_wait = 1'b1;
                            if (ph_now == PHC_TOH) ph_next = top_wait ? PHC_HW : PHC_H;
                            else ph_next = left_wait ? PHC_VW : PHC_V;
                            request_once(cfg_yellow);
                        end
                        default: ;
                    endcase
                end
                // The unused mode code leaves everything as it is.
                default: ;
            endcase
        end
        res.lamps = lamp_bits;
        res.timer_request = req_on;
        res.hold_ms = hold_val;
        res.top_waiting = top_wait;
        res.left_waiting = left_wait;
        res.phase = ph_now;
        return res;
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Sensor bits are {top_ped, left_ped, top_car, bottom_car, left_car, right_car}.
    function automatic void add_item(logic op, logic [5:0] sense, logic [31:0] now);
        t_in_item it;
        it.op = op;
        {it.top_ped, it.left_ped, it.top_car, it.bottom_car, it.left_car, it.right_car} = sense;
        it.now_ms = now;
        sensor_q.push_back(it);
    endfunction

    // Buttons are pressed less often than cars arrive, so car paths stay reachable.
    function automatic logic [5:0] random_sense();
        logic [3:0] cars;
        cars = 4'($urandom_range(0, 15));
        return {($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0), cars};
    endfunction

    function automatic logic [15:0] pick_delay();
        logic [15:0] dly;
        case ($urandom_range(0, 4))
            0: dly = 16'h0000;
            1: dly = 16'hFFFF;
            2: dly = 16'($urandom_range(1, 20));
            default: dly = 16'($urandom);
        endcase
        return dly;
    endfunction

    // One register write over the configuration channel; the predictor follows on transfer.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:     cfg_mode = data[1:0];
            CFG_PED_WAIT: cfg_ped_wait = data;
            CFG_WALKING:  cfg_walking = data;
            CFG_YELLOW:   cfg_yellow = data;
            CFG_GREEN:    cfg_green = data;
            CFG_RED_MAX:  cfg_red_max = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [15:0] mode_word, logic [15:0] ped, logic [15:0] walk,
                             logic [15:0] yel, logic [15:0] grn, logic [15:0] red);
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_PED_WAIT, ped);
        write_reg(CFG_WALKING, walk);
        write_reg(CFG_YELLOW, yel);
        write_reg(CFG_GREEN, grn);
        write_reg(CFG_RED_MAX, red);
    endtask

    // Block until every queued item went in and every result came out, then let it settle.
    task automatic wait_idle();
        while (sensor_q.size() != 0 || accepted_cnt != issued_cnt || lights_due_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Input driver: one item per transfer, with a drawn gap before each new item.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (accepted_cnt == issued_cnt) begin
            if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (sensor_q.size() != 0) begin
                i_in_data <= sensor_q.pop_front();
                i_in_valid <= 1'b1;
                issued_cnt++;
                in_gap = $urandom_range(0, in_gap_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink: after each result transfer, hold ready low for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (result_cnt != results_seen) begin
            results_seen = result_cnt;
            out_gap = $urandom_range(0, out_gap_max);
        end
        if (out_gap > 0) begin
            i_out_ready <= 1'b0;
            out_gap--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, check on result transfers, watch for a hang.
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            lights_due_q.push_back(crossing_outcome(i_in_data));
            accepted_cnt++;
            moved = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lights_due_q.size() == 0) begin
                $error("result transfer with no expected result pending");
                mismatches++;
            end else begin
                want = lights_due_q.pop_front();
                compare_field("lamps", want.lamps, o_out_data.lamps);
                compare_field("timer_request", 16'(want.timer_request),
                              16'(o_out_data.timer_request));
                compare_field("hold_ms", want.hold_ms, o_out_data.hold_ms);
                compare_field("top_waiting", 16'(want.top_waiting),
                              16'(o_out_data.top_waiting));
                compare_field("left_waiting", 16'(want.left_waiting),
                              16'(o_out_data.left_waiting));
                compare_field("phase", 16'(want.phase), 16'(o_out_data.phase));
            end
            result_cnt++;
            moved = 1'b1;
        end
        if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[traffic_crossing_controller_top] ERROR");
            $finish;
        end
    end

    // Stimulus: directed walk through every mode, then random runs with fresh settings.
    initial begin
        int          run;
        int          n;
        int          burst;
        logic [1:0]  mode;
        logic [15:0] mode_word;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One lane: full cycle H, to V, V walk, to H and back, with field extremes.
        configure({14'd0, MODE_ONE_LANE_PED}, 16'h0005, 16'hFFFF, 16'h0000, 16'h0001,
                  16'hFFFF);
        add_item(OP_SAMPLE, 6'b000000, 32'h0000_0000);
        add_item(OP_SAMPLE, 6'b111111, 32'hFFFF_FFFF);
        add_item(OP_ADVANCE, 6'b000000, 32'd10);
        add_item(OP_SAMPLE, 6'b100000, 32'd20);
        add_item(OP_ADVANCE, 6'b111111, 32'd25);
        add_item(OP_SAMPLE, 6'b010101, 32'd30);
        add_item(OP_ADVANCE, 6'b000000, 32'd35);
        add_item(OP_SAMPLE, 6'b001010, 32'd40);
        add_item(OP_ADVANCE, 6'b000000, 32'd45);
        add_item(OP_SAMPLE, 6'b000000, 32'd50);
        wait_idle();

        // Unused mode code, written with all upper bits set: samples change nothing.
        configure(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        add_item(OP_SAMPLE, 6'b111111, 32'h8000_0000);
        add_item(OP_ADVANCE, 6'b000000, 32'h8000_0001);
        wait_idle();

        // Two lanes: yellow into V, then a car only on the red road.
        configure({14'd0, MODE_TWO_LANE}, 16'h1234, 16'h0010, 16'h0003, 16'hFFFF, 16'h0000);
        add_item(OP_SAMPLE, 6'b001100, 32'd100);
        add_item(OP_ADVANCE, 6'b000000, 32'd101);
        add_item(OP_SAMPLE, 6'b000011, 32'd102);
        add_item(OP_SAMPLE, 6'b111111, 32'd103);
        wait_idle();

        // One lane while sitting in V: a phase that mode does not use.
        configure(16'hFFFC, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009);
        add_item(OP_SAMPLE, 6'b111111, 32'd200);
        wait_idle();

        // Two lanes with pedestrians: wrapped expiry, walk request, both walk phases.
        configure({14'd0, MODE_TWO_LANE_PED}, 16'd300, 16'd0, 16'd2, 16'hFFFF, 16'd0);
        add_item(OP_SAMPLE, 6'b100011, 32'hFFFF_FFF0);
        add_item(OP_SAMPLE, 6'b010000, 32'h0000_0000);
        add_item(OP_ADVANCE, 6'b000000, 32'd1);
        add_item(OP_SAMPLE, 6'b100000, 32'd5);
        add_item(OP_ADVANCE, 6'b000000, 32'd6);
        add_item(OP_SAMPLE, 6'b010000, 32'd7);
        add_item(OP_ADVANCE, 6'b000000, 32'd8);
        add_item(OP_SAMPLE, 6'b001100, 32'd9);
        wait_idle();

        // Random runs: mostly a few samples then an advance, with some pure noise.
        for (run = 0; run < RANDOM_RUNS; run++) begin
            if (run < 3) mode = 2'(run);
            else if ($urandom_range(0, 7) == 0) mode = MODE_UNUSED;
            else mode = 2'($urandom_range(0, 2));
            mode_word = 16'($urandom);
            if ($urandom_range(0, 1) == 0) mode_word[15:2] = '0;
            mode_word[1:0] = mode;
            if (run == 1) begin
                in_gap_max = 0;
                out_gap_max = 0;
            end else begin
                in_gap_max = $urandom_range(0, 1) ? 18 : 0;
                out_gap_max = $urandom_range(0, 1) ? 18 : 0;
            end
            configure(mode_word, pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                      pick_delay());
            case ($urandom_range(0, 2))
                0: clock_ms = $urandom_range(0, 60000);
                1: clock_ms = $urandom;
                default: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40000);
            endcase
            n = 0;
            while (n < ITEMS_PER_RUN) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom);
                    n++;
                end else begin
                    burst = $urandom_range(1, 3);
                    repeat (burst) begin
                        clock_ms += $urandom_range(0, 2500);
                        add_item(OP_SAMPLE, random_sense(), clock_ms);
                        n++;
                    end
                    add_item(OP_ADVANCE, random_sense(), clock_ms);
                    n++;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("[traffic_crossing_controller_top] OK");
        else
            $display("[traffic_crossing_controller_top] ERROR");
        $finish;
    end

endmodule
